// ===== design/positional_array_insert_delete_search_assert.svh =====
// assertion helpers shared by the list block
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH

// same-cycle implication
`define PAIDS_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define PAIDS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== design/paids_pkg.sv =====
`default_nettype none

package paids_pkg;

    typedef enum logic [1:0]
    {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef struct packed
    {
        op_t        operation;
        logic [5:0] position;
        logic [7:0] value;
    } in_word_t;

    typedef struct packed
    {
        logic       status;
        logic       found;
        logic [5:0] match_index;
        logic [6:0] used_count;
    } out_word_t;

    typedef struct packed
    {
        logic       apply;
        op_t        op;
        logic [5:0] pos;
        logic [7:0] val;
    } cell_ctrl_t;

    typedef struct packed
    {
        logic       done;
        logic       found;
        logic [5:0] index;
    } scan_res_t;

    localparam int SCAN_GROUP = 8;

endpackage

`default_nettype wire

// ===== design/paids_cell.sv =====
`default_nettype none

module paids_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int IW  = 7
) (
    input  wire logic                  clk,
    input  wire paids_pkg::cell_ctrl_t ctrl,
    input  wire logic [CW-1:0]         count,
    input  wire logic [7:0]            prev_data,
    input  wire logic [7:0]            next_data,
    output logic [7:0]                 data,
    output logic                       match
);
    import paids_pkg::*;

    localparam logic [IW-1:0] IDX_P = IW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [7:0]    data_reg;
    logic [7:0]    data_next;
    logic          match_reg;
    logic          match_next;
    logic [IW-1:0] pos_w;
    logic          used;

    assign pos_w = IW'(ctrl.pos);
    assign used  = IDX_C < count;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        if (ctrl.apply)
        begin
            case (ctrl.op)
                OP_INSERT:
                begin
                    if (IDX_P > pos_w)
                    begin
                        data_next = prev_data;
                    end
                    else if (IDX_P == pos_w)
                    begin
                        data_next = ctrl.val;
                    end
                end
                OP_DELETE:
                begin
                    if (IDX_P >= pos_w)
                    begin
                        data_next = next_data;
                    end
                end
                OP_UPDATE:
                begin
                    if (IDX_P == pos_w)
                    begin
                        data_next = ctrl.val;
                    end
                end
                OP_SEARCH:
                begin
                    match_next = used && (data_reg == ctrl.val);
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== design/paids_scan.sv =====
`default_nettype none

module paids_scan #(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DEPTH-1:0] match,
    output paids_pkg::scan_res_t  res
);
    import paids_pkg::*;

    localparam int NG = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam logic [GW-1:0] LAST_GRP = GW'(NG - 1);

    logic            busy_reg;
    logic            busy_next;
    logic [GW-1:0]   grp_reg;
    logic [GW-1:0]   grp_next;
    logic [NG*SCAN_GROUP-1:0] pad;
    logic [SCAN_GROUP-1:0]    bits;
    logic            hit;
    logic [2:0]      kk;
    logic [GW+5:0]   full_idx;

    always_comb
    begin
        pad            = '0;
        pad[DEPTH-1:0] = match;
    end

    assign bits = pad[{grp_reg, 3'b000} +: SCAN_GROUP];

    always_comb
    begin
        hit = 1'b0;
        kk  = 3'd0;
        for (int k = SCAN_GROUP - 1; k >= 0; k--)
        begin
            if (bits[k])
            begin
                hit = 1'b1;
                kk  = 3'(k);
            end
        end
    end

    assign full_idx = (GW + 6)'({grp_reg, kk});

    always_comb
    begin
        res.done  = busy_reg && (hit || grp_reg == LAST_GRP);
        res.found = hit;
        res.index = hit ? full_idx[5:0] : 6'd0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            grp_next  = '0;
        end
        else if (res.done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            grp_next = grp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            grp_reg  <= grp_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/positional_array_insert_delete_search.sv =====
// channel | words                | handshake
// in      | operation/position/value | in_valid, in_stall
// out     | status/found/match_index/used_count | out_valid, out_stall
//
// insert, delete and update set the cells and the result word at the same edge;
// the whole cell row shifts at once; search compares the value in every cell,
// then scans the match bits eight cells a cycle
// reset clears the used count and the handshake state; entries need no clearing
// a stalled output word holds; a new word is taken once the result register frees
`default_nettype none

module positional_array_insert_delete_search #(
    parameter int DEPTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire paids_pkg::in_word_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output paids_pkg::out_word_t      out_data
);
    import paids_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_word_t       out_data_reg;
    out_word_t       out_data_next;

    logic            accept;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic            insert_ok;
    logic            modify_ok;
    logic            op_ok;
    cell_ctrl_t      ctrl;
    scan_res_t       scan_res;
    logic [7:0]      cell_data [DEPTH];
    logic [DEPTH-1:0] match_vec;

    assign in_stall = !(state_reg == ST_IDLE && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    assign pos_w     = CMPW'(in_data.position);
    assign cnt_w     = CMPW'(count_reg);
    assign insert_ok = (cnt_w < CMPW'(DEPTH)) && (pos_w <= cnt_w);
    assign modify_ok = pos_w < cnt_w;

    always_comb
    begin
        case (in_data.operation)
            OP_INSERT: op_ok = insert_ok;
            OP_DELETE: op_ok = modify_ok;
            OP_UPDATE: op_ok = modify_ok;
            OP_SEARCH: op_ok = 1'b1;
            default:   op_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl.apply = accept && op_ok;
        ctrl.op    = in_data.operation;
        ctrl.pos   = in_data.position;
        ctrl.val   = in_data.value;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] prev_d;
        logic [7:0] next_d;
        if (i == 0)
        begin : g_first
            assign prev_d = 8'h00;
        end
        else
        begin : g_mid_lo
            assign prev_d = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = 8'h00;
        end
        else
        begin : g_mid_hi
            assign next_d = cell_data[i+1];
        end
        paids_cell #(
            .IDX (i),
            .CW  (CW),
            .IW  (CMPW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .match     (match_vec[i])
        );
    end

    paids_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && in_data.operation == OP_SEARCH),
        .match (match_vec),
        .res   (scan_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == OP_SEARCH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (op_ok && in_data.operation == OP_INSERT)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else if (op_ok && in_data.operation == OP_DELETE)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        out_valid_next            = 1'b1;
                        out_data_next.status      = !op_ok;
                        out_data_next.found       = 1'b0;
                        out_data_next.match_index = 6'd0;
                        out_data_next.used_count  = 7'(count_next);
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next                = ST_IDLE;
                    out_valid_next            = 1'b1;
                    out_data_next.status      = 1'b0;
                    out_data_next.found       = scan_res.found;
                    out_data_next.match_index = scan_res.index;
                    out_data_next.used_count  = 7'(count_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "positional_array_insert_delete_search_assert.svh"

    `PAIDS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "count past depth")
    `PAIDS_ASSERT_NEXT(a_write_result, clk, rst_n, accept && in_data.operation != OP_SEARCH, out_valid_reg, "no result for write")
    `PAIDS_ASSERT_NEXT(a_search_scan, clk, rst_n, accept && in_data.operation == OP_SEARCH, state_reg == ST_SCAN && !out_valid_reg, "search did not scan")
    `PAIDS_ASSERT_NEXT(a_reject_hold, clk, rst_n, accept && !op_ok, $stable(count_reg), "rejected word moved count")

endmodule

`default_nettype wire

// ===== dv/paids_list_monitor.sv =====
`timescale 1ns / 100ps

module paids_list_monitor #(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  paids_pkg::in_word_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  paids_pkg::out_word_t out_data,
    output int                   err_count,
    output int                   pending,
    output int                   shadow_len
);

    import paids_pkg::*;

    logic [7:0] shadow_list [0:DEPTH-1];
    out_word_t  replies_due [$];
    out_word_t  want;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (err_count < 100)
            $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        err_count++;
    endtask

    // apply one request word to the shadow list and return its reply word
    function automatic out_word_t apply_request(input in_word_t w);
        out_word_t r;
        int pos;
        r = '0;
        pos = int'(w.position);
        case (w.operation)
            OP_INSERT:
            begin
                if (shadow_len >= DEPTH || pos > shadow_len)
                    r.status = 1'b1;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = w.value;
                    shadow_len++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= shadow_len)
                    r.status = 1'b1;
                else
                begin
                    for (int i = pos + 1; i < shadow_len; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_len--;
                end
            end
            OP_UPDATE:
            begin
                if (pos >= shadow_len)
                    r.status = 1'b1;
                else
                    shadow_list[pos] = w.value;
            end
            default:
            begin
                // lowest used position wins
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (shadow_list[i] == w.value)
                    begin
                        r.found = 1'b1;
                        r.match_index = i[5:0];
                        break;
                    end
                end
            end
        endcase
        r.used_count = shadow_len[6:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            replies_due.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("word with none expected", int'(out_data), 0);
                else
                begin
                    want = replies_due.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.found !== want.found)
                        report_mismatch("found", out_data.found, want.found);
                    if (out_data.match_index !== want.match_index)
                        report_mismatch("match_index", out_data.match_index, want.match_index);
                    if (out_data.used_count !== want.used_count)
                        report_mismatch("used_count", out_data.used_count, want.used_count);
                end
            end
            if (in_valid && !in_stall)
                replies_due.push_back(apply_request(in_data));
            pending = replies_due.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import paids_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int CYCLE_LIMIT = 300000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;

    int err_count;
    int pending;
    int shadow_len;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_cnt;

    positional_array_insert_delete_search #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    paids_list_monitor #(
        .DEPTH(LIST_DEPTH)
    ) u_mon (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .err_count (err_count),
        .pending   (pending),
        .shadow_len(shadow_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

    task automatic send_req(input op_t op, input int pos, input int val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{operation: op, position: pos[5:0], value: val[7:0]};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // random word shaped by the current list length; grow_pct biases toward inserts
    task automatic send_random(input int grow_pct);
        op_t op;
        int  pos;
        int  val;
        int  r;
        r = $urandom_range(99);
        if (r < grow_pct)
            op = OP_INSERT;
        else
        begin
            r = $urandom_range(99);
            op = (r < 40) ? OP_DELETE : (r < 60) ? OP_UPDATE : OP_SEARCH;
        end
        if ($urandom_range(99) < 15)
            pos = $urandom_range(63);
        else if (op == OP_INSERT)
            pos = (shadow_len > 63) ? 63 : $urandom_range(shadow_len);
        else
            pos = (shadow_len > 0) ? $urandom_range(shadow_len - 1) : 0;
        r = $urandom_range(99);
        val = (r < 40) ? $urandom_range(7) : (r < 50) ? 8'hFF : $urandom_range(255);
        send_req(op, pos, val);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 15;
        recv_stall_pct = 50;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list corner cases
        send_req(OP_SEARCH, 0, 8'h00);
        send_req(OP_DELETE, 0, 8'h00);
        send_req(OP_UPDATE, 0, 8'hFF);
        send_req(OP_INSERT, 1, 8'h11);
        // front, append and duplicate inserts
        send_req(OP_INSERT, 0, 8'hFF);
        send_req(OP_INSERT, 1, 8'h00);
        send_req(OP_INSERT, 0, 8'hA5);
        send_req(OP_INSERT, 3, 8'hFF);
        send_req(OP_INSERT, 63, 8'h22);
        send_req(OP_SEARCH, 0, 8'hFF);
        send_req(OP_UPDATE, 4, 8'h33);
        send_req(OP_UPDATE, 2, 8'hFF);
        send_req(OP_UPDATE, 63, 8'h44);
        send_req(OP_SEARCH, 63, 8'h00);
        send_req(OP_SEARCH, 0, 8'hA5);
        send_req(OP_DELETE, 4, 8'h00);
        send_req(OP_DELETE, 63, 8'hFF);
        send_req(OP_DELETE, 0, 8'h00);
        send_req(OP_DELETE, 2, 8'h00);
        send_req(OP_SEARCH, 0, 8'hFF);
        send_req(OP_UPDATE, 0, 8'h00);
        send_req(OP_SEARCH, 0, 8'h00);
        wait_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 15 : 0;
            // fill past full, then shrink
            for (int n = 0; n < 100; n++)
                send_random(90);
            wait_drain();
            for (int n = 0; n < 50; n++)
                send_random(10);
            wait_drain();
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
